// File: src/odft_pkg.sv
package odft_pkg;

  // Default build parameters
  localparam int SAMPLES_DEF      = 64;
  localparam int TWIDDLE_BITS_DEF = 16;

  // Frame position width, enough for the largest frame
  localparam int CNT_W = 7;

  // Depth of the queue between front and back
  localparam int QDEPTH = 2;

  // CORDIC constants
  localparam int          CORDIC_STEPS = 30;
  localparam int          VEC_EXTRA    = 12;
  localparam logic [29:0] GAIN_INV     = 30'd652032874;

  // Register index of the configuration port
  localparam logic REG_NEGATE_IMAG = 1'b0;

  // Arctangent of 2^-i in units of 2^32 per turn
  localparam logic [31:0] ATAN_TURNS [CORDIC_STEPS] = '{
    32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2E,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2F9,
    32'h0000517C, 32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
    32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051, 32'h00000028,
    32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000002, 32'h00000001
  };

  // One sample as it travels from front to back
  typedef struct packed {
    logic signed [15:0] sample;
    logic [CNT_W-1:0]   n;
    logic               first;
    logic               last;
  } q_item_t;

  // Twiddle by CORDIC rotation, Q1.frac, angle in 2^32 per turn
  function automatic longint tw_calc(input longint angle, input int frac,
                                     input bit want_sin);
    longint x;
    longint y;
    longint z;
    longint nx;
    longint c;
    longint s;
    logic [1:0] quad;
    quad = angle[31:30];
    z = angle & 64'h3FFF_FFFF;
    x = longint'(GAIN_INV);
    y = 0;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y  = y + (x >>> i);
        z  = z - longint'(ATAN_TURNS[i]);
      end else begin
        nx = x + (y >>> i);
        y  = y - (x >>> i);
        z  = z + longint'(ATAN_TURNS[i]);
      end
      x = nx;
    end
    x = (x + (longint'(1) <<< (29 - frac))) >>> (30 - frac);
    y = (y + (longint'(1) <<< (29 - frac))) >>> (30 - frac);
    case (quad)
      2'd0: begin c = x;  s = y;  end
      2'd1: begin c = -y; s = x;  end
      2'd2: begin c = -x; s = -y; end
      default: begin c = y; s = -x; end
    endcase
    return want_sin ? s : c;
  endfunction

endpackage

// File: src/odft_front.sv
module odft_front #(
  parameter int SAMPLES = odft_pkg::SAMPLES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic signed [15:0] in_sample,
  output logic               in_stall,
  input  logic               q_full,
  output logic               q_push,
  output odft_pkg::q_item_t  q_item
);

  logic [odft_pkg::CNT_W-1:0] count_r;
  logic [odft_pkg::CNT_W-1:0] count_nxt;
  logic                       is_last;

  // Tag each sample with its frame position
  assign is_last  = (count_r == odft_pkg::CNT_W'(SAMPLES - 1));
  assign q_push   = in_valid && !q_full;
  assign in_stall = q_full;

  always_comb begin
    q_item.sample = in_sample;
    q_item.n      = count_r;
    q_item.first  = (count_r == '0);
    q_item.last   = is_last;
  end

  // Advance the frame position, wrap after the last sample
  always_comb begin
    count_nxt = count_r;
    if (q_push) begin
      count_nxt = is_last ? '0 : count_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

endmodule

// File: src/odft_fifo.sv
module odft_fifo (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  odft_pkg::q_item_t push_item,
  input  logic              pop,
  output odft_pkg::q_item_t pop_item,
  output logic              empty,
  output logic              full
);

  localparam int PTR_W = $clog2(odft_pkg::QDEPTH);

  odft_pkg::q_item_t entries_r [odft_pkg::QDEPTH];
  logic [PTR_W-1:0]  wr_ptr_r;
  logic [PTR_W-1:0]  rd_ptr_r;
  logic [PTR_W:0]    cnt_r;

  assign empty    = (cnt_r == '0);
  assign full     = (cnt_r == (PTR_W+1)'(odft_pkg::QDEPTH));
  assign pop_item = entries_r[rd_ptr_r];

  // Hold entries
  always_ff @(posedge clk) begin
    if (push) begin
      entries_r[wr_ptr_r] <= push_item;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(odft_pkg::QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(odft_pkg::QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

// File: src/odft_back.sv
module odft_back #(
  parameter int SAMPLES      = odft_pkg::SAMPLES_DEF,
  parameter int TWIDDLE_BITS = odft_pkg::TWIDDLE_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_empty,
  input  odft_pkg::q_item_t  q_item,
  output logic               q_pop,
  input  logic               negate_imag,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [6:0]         out_bin_index,
  output logic signed [17:0] out_real_part,
  output logic signed [17:0] out_imag_part,
  output logic [17:0]        out_magnitude,
  output logic signed [15:0] out_phase_angle,
  output logic               out_last_bin
);

  localparam int NBINS     = SAMPLES / 2 + 1;
  localparam int FRAC      = TWIDDLE_BITS - 2;
  localparam int MW        = $clog2(SAMPLES);
  localparam int AW        = $clog2(NBINS);
  localparam int KW        = $clog2(NBINS + 2);
  localparam int PW        = 16 + TWIDDLE_BITS;
  localparam int DIV_STEPS = 2;
  localparam int RCP_SHIFT = 31;
  localparam longint      DEN      = longint'(SAMPLES) << FRAC;
  localparam logic [41:0] HALF_DEN = 42'(DEN / 2);
  localparam logic [41:0] CLAMP    = 42'(SAMPLES) << 17;
  localparam logic [31:0] RECIP    =
    32'(((longint'(1) << RCP_SHIFT) + longint'(SAMPLES) - 1) / longint'(SAMPLES));

  typedef enum logic [8:0] {
    ST_IDLE = 9'b000000001,
    ST_ACC  = 9'b000000010,
    ST_ORD  = 9'b000000100,
    ST_OLD  = 9'b000001000,
    ST_DIV  = 9'b000010000,
    ST_VIN  = 9'b000100000,
    ST_VEC  = 9'b001000000,
    ST_VMUL = 9'b010000000,
    ST_EMIT = 9'b100000000
  } state_t;

  state_t          state_r;
  state_t          state_nxt;
  logic [KW-1:0]   k_r;
  logic [KW-1:0]   k_nxt;
  logic [MW-1:0]   m_r;
  logic [MW-1:0]   m_nxt;
  logic [4:0]      s_r;
  logic [4:0]      s_nxt;
  logic [MW:0]     m_sum;
  logic [MW-1:0]   m_step;
  logic            issue;
  logic            load_out;
  logic            out_free;
  logic            out_valid_r;
  logic            out_valid_nxt;

  // Current item
  logic signed [15:0] samp_r;
  logic [MW-1:0]      n_r;
  logic               first_r;
  logic               last_r;

  // Twiddle tables
  logic signed [TWIDDLE_BITS-1:0] tw_cos_a [SAMPLES];
  logic signed [TWIDDLE_BITS-1:0] tw_sin_a [SAMPLES];

  // Accumulate pipeline
  logic                           s1_v_r;
  logic [AW-1:0]                  s1_a_r;
  logic signed [TWIDDLE_BITS-1:0] tw_c_r;
  logic signed [TWIDDLE_BITS-1:0] tw_s_r;
  logic                           s2_v_r;
  logic [AW-1:0]                  s2_a_r;
  logic signed [PW-1:0]           pr_re_r;
  logic signed [PW-1:0]           pr_im_r;
  logic signed [39:0]             acc2_re_r;
  logic signed [39:0]             acc2_im_r;

  // Accumulator memories
  logic signed [39:0] mem_re [NBINS];
  logic signed [39:0] mem_im [NBINS];
  logic signed [39:0] rd_re_r;
  logic signed [39:0] rd_im_r;
  logic [AW-1:0]      rd_addr;

  // Output scaling
  logic [41:0] nr_re_r;
  logic [41:0] nr_im_r;
  logic        neg_re_r;
  logic        neg_im_r;
  logic [41:0] sh_re;
  logic [41:0] sh_im;
  logic [23:0] nc_re_r;
  logic [23:0] nc_im_r;
  logic [55:0] qp_re;
  logic [55:0] qp_im;
  logic [17:0] q_re_r;
  logic [17:0] q_im_r;
  logic [39:0] mag_re;
  logic [39:0] mag_im;

  // Vectoring
  logic signed [17:0] re_r;
  logic signed [17:0] im_r;
  logic signed [17:0] re_v;
  logic signed [17:0] im_v;
  logic signed [32:0] x_r;
  logic signed [32:0] y_r;
  logic [31:0]        z_r;
  logic               zero_r;
  logic signed [32:0] x0;
  logic signed [32:0] y0;
  logic signed [32:0] xs;
  logic signed [32:0] ys;
  logic               y_pos;
  logic [61:0]        prod_r;
  logic [61:0]        m_full;
  logic [17:0]        mag_v;
  logic [31:0]        ph_full;

  // Result register
  logic [6:0]         out_bin_r;
  logic signed [17:0] out_re_r;
  logic signed [17:0] out_im_r;
  logic [17:0]        out_mag_r;
  logic signed [15:0] out_ph_r;
  logic               out_last_r;

  function automatic logic signed [39:0] sat40(input logic signed [40:0] v);
    if (v[40] != v[39]) begin
      return v[40] ? {1'b1, {39{1'b0}}} : {1'b0, {39{1'b1}}};
    end
    return v[39:0];
  endfunction

  function automatic logic signed [17:0] qfix(input logic [17:0] q, input logic neg);
    logic signed [17:0] m;
    m = {1'b0, q[16:0]};
    if (q[17]) begin
      return neg ? 18'sh20000 : 18'sh1FFFF;
    end
    return neg ? -m : m;
  endfunction

  // Build twiddle constants
  for (genvar g = 0; g < SAMPLES; g++) begin : g_tw
    localparam longint ANG = (longint'(g) << 32) / SAMPLES;
    assign tw_cos_a[g] = TWIDDLE_BITS'(odft_pkg::tw_calc(ANG, FRAC, 1'b0));
    assign tw_sin_a[g] = TWIDDLE_BITS'(odft_pkg::tw_calc(ANG, FRAC, 1'b1));
  end

  // Step twiddle index by n modulo the frame length
  assign m_sum  = {1'b0, m_r} + {1'b0, n_r};
  assign m_step = (m_sum >= (MW+1)'(SAMPLES)) ? MW'(m_sum - (MW+1)'(SAMPLES)) : m_sum[MW-1:0];

  assign issue    = (state_r == ST_ACC) && (k_r < KW'(NBINS));
  assign rd_addr  = (k_r < KW'(NBINS)) ? k_r[AW-1:0] : '0;
  assign out_free = !out_valid_r || !out_stall;

  // Sequence accumulate passes and bin output
  always_comb begin
    state_nxt = state_r;
    k_nxt     = k_r;
    m_nxt     = m_r;
    s_nxt     = s_r;
    q_pop     = 1'b0;
    load_out  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (!q_empty) begin
          q_pop     = 1'b1;
          k_nxt     = '0;
          m_nxt     = '0;
          state_nxt = ST_ACC;
        end
      end
      ST_ACC: begin
        k_nxt = k_r + 1'b1;
        m_nxt = m_step;
        if (k_r == KW'(NBINS + 1)) begin
          k_nxt     = '0;
          state_nxt = last_r ? ST_ORD : ST_IDLE;
        end
      end
      ST_ORD: begin
        state_nxt = ST_OLD;
      end
      ST_OLD: begin
        s_nxt     = '0;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        s_nxt = s_r + 1'b1;
        if (s_r == 5'(DIV_STEPS - 1)) begin
          s_nxt     = '0;
          state_nxt = ST_VIN;
        end
      end
      ST_VIN: begin
        s_nxt     = '0;
        state_nxt = ST_VEC;
      end
      ST_VEC: begin
        s_nxt = s_r + 1'b1;
        if (s_r == 5'(odft_pkg::CORDIC_STEPS - 1)) begin
          s_nxt     = '0;
          state_nxt = ST_VMUL;
        end
      end
      ST_VMUL: begin
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) begin
          load_out = 1'b1;
          if (k_r == KW'(NBINS - 1)) begin
            k_nxt     = '0;
            state_nxt = ST_IDLE;
          end else begin
            k_nxt     = k_r + 1'b1;
            state_nxt = ST_ORD;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Hold the result until taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      k_r         <= '0;
      m_r         <= '0;
      s_r         <= '0;
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      k_r         <= k_nxt;
      m_r         <= m_nxt;
      s_r         <= s_nxt;
      s1_v_r      <= issue;
      s2_v_r      <= s1_v_r;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Latch the popped transaction
  always_ff @(posedge clk) begin
    if (q_pop) begin
      samp_r  <= q_item.sample;
      n_r     <= q_item.n[MW-1:0];
      first_r <= q_item.first;
      last_r  <= q_item.last;
    end
  end

  // Accumulator memories: one read, one write per cycle
  always_ff @(posedge clk) begin
    rd_re_r <= mem_re[rd_addr];
    rd_im_r <= mem_im[rd_addr];
    if (s2_v_r) begin
      mem_re[s2_a_r] <= sat40(41'(acc2_re_r) + 41'(pr_re_r));
      mem_im[s2_a_r] <= sat40(41'(acc2_im_r) + 41'(pr_im_r));
    end
  end

  // Twiddle lookup, then multiply; first sample of a frame starts from zero
  always_ff @(posedge clk) begin
    tw_c_r    <= tw_cos_a[m_r];
    tw_s_r    <= negate_imag ? -tw_sin_a[m_r] : tw_sin_a[m_r];
    s1_a_r    <= k_r[AW-1:0];
    pr_re_r   <= PW'(samp_r) * PW'(tw_c_r);
    pr_im_r   <= PW'(samp_r) * PW'(tw_s_r);
    acc2_re_r <= first_r ? '0 : rd_re_r;
    acc2_im_r <= first_r ? '0 : rd_im_r;
    s2_a_r    <= s1_a_r;
  end

  // Scale |2*acc| + den/2 by 1/den: drop the twiddle fraction, clamp where the
  // quotient saturates anyway, then multiply by the frame-length reciprocal
  assign mag_re = rd_re_r[39] ? 40'(-rd_re_r) : 40'(rd_re_r);
  assign mag_im = rd_im_r[39] ? 40'(-rd_im_r) : 40'(rd_im_r);
  assign sh_re  = nr_re_r >> FRAC;
  assign sh_im  = nr_im_r >> FRAC;
  assign qp_re  = 56'(nc_re_r) * 56'(RECIP);
  assign qp_im  = 56'(nc_im_r) * 56'(RECIP);

  always_ff @(posedge clk) begin
    if (state_r == ST_OLD) begin
      nr_re_r  <= {1'b0, mag_re, 1'b0} + HALF_DEN;
      nr_im_r  <= {1'b0, mag_im, 1'b0} + HALF_DEN;
      neg_re_r <= rd_re_r[39];
      neg_im_r <= rd_im_r[39];
    end else if (state_r == ST_DIV) begin
      if (s_r == '0) begin
        nc_re_r <= (sh_re >= CLAMP) ? CLAMP[23:0] : sh_re[23:0];
        nc_im_r <= (sh_im >= CLAMP) ? CLAMP[23:0] : sh_im[23:0];
      end else begin
        q_re_r <= qp_re[RCP_SHIFT+17:RCP_SHIFT];
        q_im_r <= qp_im[RCP_SHIFT+17:RCP_SHIFT];
      end
    end
  end

  // Vectoring CORDIC
  assign re_v  = qfix(q_re_r, neg_re_r);
  assign im_v  = qfix(q_im_r, neg_im_r);
  assign x0    = 33'(re_v) <<< odft_pkg::VEC_EXTRA;
  assign y0    = 33'(im_v) <<< odft_pkg::VEC_EXTRA;
  assign xs    = x_r >>> s_r;
  assign ys    = y_r >>> s_r;
  assign y_pos = !y_r[32] && (y_r != '0);

  always_ff @(posedge clk) begin
    if (state_r == ST_VIN) begin
      re_r   <= re_v;
      im_r   <= im_v;
      zero_r <= (re_v == '0) && (im_v == '0);
      if (re_v[17]) begin
        x_r <= -x0;
        y_r <= -y0;
        z_r <= 32'h8000_0000;
      end else begin
        x_r <= x0;
        y_r <= y0;
        z_r <= '0;
      end
    end else if (state_r == ST_VEC) begin
      if (y_pos) begin
        x_r <= x_r + ys;
        y_r <= y_r - xs;
        z_r <= z_r + odft_pkg::ATAN_TURNS[s_r];
      end else begin
        x_r <= x_r - ys;
        y_r <= y_r + xs;
        z_r <= z_r - odft_pkg::ATAN_TURNS[s_r];
      end
    end else if (state_r == ST_VMUL) begin
      prod_r <= 62'(x_r[31:0]) * 62'(odft_pkg::GAIN_INV);
    end
  end

  // Gain-correct, round and saturate the magnitude; round the phase
  assign m_full  = prod_r + (62'(1) << (29 + odft_pkg::VEC_EXTRA));
  assign mag_v   = (m_full[61:42] > 20'd262143) ? 18'h3FFFF : m_full[59:42];
  assign ph_full = z_r + 32'h0000_8000;

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_bin_r  <= 7'(k_r);
      out_re_r   <= re_r;
      out_im_r   <= im_r;
      out_mag_r  <= zero_r ? '0 : mag_v;
      out_ph_r   <= zero_r ? '0 : ph_full[31:16];
      out_last_r <= (k_r == KW'(NBINS - 1));
    end
  end

  assign out_valid       = out_valid_r;
  assign out_bin_index   = out_bin_r;
  assign out_real_part   = out_re_r;
  assign out_imag_part   = out_im_r;
  assign out_magnitude   = out_mag_r;
  assign out_phase_angle = out_ph_r;
  assign out_last_bin    = out_last_r;

endmodule

// File: src/one_sided_dft_spectrum.sv
// Channel  Handshake                      Payload
// in       in_valid / in_stall            in_sample
// out      out_valid / out_stall          out_bin_index, out_real_part, out_imag_part,
//                                         out_magnitude, out_phase_angle, out_last_bin
// cfg      psel, penable, pwrite, pready  paddr, pwdata, prdata
//
// Each sample makes a pass over the bins in the back end, plus pipeline fill and queue pop:
// the accumulator memory port updates one bin per cycle; the next sample waits for the pass.
// After the last sample of a frame each bin runs a two-step reciprocal scaling and a
// 30-step CORDIC one after the other, plus a wait on a stalled result.
// Reset clears control state and the frame position; a partial frame is discarded.
// Until full, the input queue takes samples while the back end works or the result stalls.
module one_sided_dft_spectrum #(
  parameter int SAMPLES      = odft_pkg::SAMPLES_DEF,
  parameter int TWIDDLE_BITS = odft_pkg::TWIDDLE_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] in_sample,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [6:0]         out_bin_index,
  output logic signed [17:0] out_real_part,
  output logic signed [17:0] out_imag_part,
  output logic [17:0]        out_magnitude,
  output logic signed [15:0] out_phase_angle,
  output logic               out_last_bin,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int NBINS = SAMPLES / 2 + 1;

  odft_pkg::q_item_t push_item;
  odft_pkg::q_item_t pop_item;
  logic              q_push;
  logic              q_pop;
  logic              q_empty;
  logic              q_full;
  logic              negate_r;
  logic              reg_hit;

  // Configuration register
  assign pready  = 1'b1;
  assign reg_hit = (paddr[2] == odft_pkg::REG_NEGATE_IMAG);
  assign prdata  = reg_hit ? {31'b0, negate_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      negate_r <= 1'b0;
    end else if (psel && penable && pwrite && reg_hit) begin
      negate_r <= pwdata[0];
    end
  end

  odft_front #(
    .SAMPLES(SAMPLES)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_sample(in_sample),
    .in_stall (in_stall),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_item   (push_item)
  );

  odft_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_item(push_item),
    .pop      (q_pop),
    .pop_item (pop_item),
    .empty    (q_empty),
    .full     (q_full)
  );

  odft_back #(
    .SAMPLES     (SAMPLES),
    .TWIDDLE_BITS(TWIDDLE_BITS)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_empty        (q_empty),
    .q_item         (pop_item),
    .q_pop          (q_pop),
    .negate_imag    (negate_r),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_bin_index  (out_bin_index),
    .out_real_part  (out_real_part),
    .out_imag_part  (out_imag_part),
    .out_magnitude  (out_magnitude),
    .out_phase_angle(out_phase_angle),
    .out_last_bin   (out_last_bin)
  );

`ifndef ASSERT_OFF
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty)
    else $error("queue popped while empty");

  a_last_bin_index: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last_bin) |-> (out_bin_index == 7'(NBINS - 1)))
    else $error("last mark on wrong bin");

  a_bin_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_last_bin) |-> (out_bin_index < 7'(NBINS - 1)))
    else $error("bin index out of range");
`endif

endmodule

// File: test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  localparam int NPTS   = odft_pkg::SAMPLES_DEF;
  localparam int FRAC   = odft_pkg::TWIDDLE_BITS_DEF - 2;
  localparam int NBINS  = NPTS / 2 + 1;
  localparam longint ACC_HI = 64'sd549755813887;
  localparam longint ACC_LO = -ACC_HI - 1;
  localparam logic [2:0] ADDR_NEGATE = 3'(odft_pkg::REG_NEGATE_IMAG) << 2;
  localparam logic [2:0] ADDR_UNUSED = 3'd4;

  typedef struct {
    logic [6:0]         idx;
    logic signed [17:0] re;
    logic signed [17:0] im;
    logic [17:0]        mag;
    logic signed [15:0] ph;
    logic               last;
  } bin_t;

  // Spectrum predictor and store of expected bins
  class spectrum_sb;
    longint cos_tab[NPTS];
    longint sin_tab[NPTS];
    longint re_acc[NBINS];
    longint im_acc[NBINS];
    int     pos;
    bit     neg;
    bin_t   bins_q[$];
    int     mismatches;
    int     bins_seen;
    int     frames_seen;

    function new();
      for (int m = 0; m < NPTS; m++) rotate_unit(longint'(m) << 26, cos_tab[m], sin_tab[m]);
      clear_frame();
      neg = 0;
      mismatches = 0;
      bins_seen = 0;
      frames_seen = 0;
    endfunction

    function void clear_frame();
      for (int k = 0; k < NBINS; k++) begin
        re_acc[k] = 0;
        im_acc[k] = 0;
      end
      pos = 0;
    endfunction

    // Twiddle pair by CORDIC rotation, angle in 2^32 per turn
    function void rotate_unit(input longint angle, output longint c, output longint s);
      longint x, y, z, nx;
      logic [1:0] quad;
      quad = angle[31:30];
      z = angle & 64'h3FFF_FFFF;
      x = longint'(odft_pkg::GAIN_INV);
      y = 0;
      for (int i = 0; i < odft_pkg::CORDIC_STEPS; i++) begin
        if (z >= 0) begin
          nx = x - (y >>> i);
          y = y + (x >>> i);
          z = z - longint'(odft_pkg::ATAN_TURNS[i]);
        end else begin
          nx = x + (y >>> i);
          y = y - (x >>> i);
          z = z + longint'(odft_pkg::ATAN_TURNS[i]);
        end
        x = nx;
      end
      x = (x + (longint'(1) <<< (29 - FRAC))) >>> (30 - FRAC);
      y = (y + (longint'(1) <<< (29 - FRAC))) >>> (30 - FRAC);
      case (quad)
        2'd0: begin c = x; s = y; end
        2'd1: begin c = -y; s = x; end
        2'd2: begin c = -x; s = -y; end
        default: begin c = y; s = -x; end
      endcase
    endfunction

    function longint clip40(input longint v);
      if (v > ACC_HI) return ACC_HI;
      if (v < ACC_LO) return ACC_LO;
      return v;
    endfunction

    // Scale by 2/N with rounding away from zero, saturate to 18 bits
    function longint scale_bin(input longint acc);
      longint num, mg, q;
      num = acc * 2;
      mg = (num < 0) ? -num : num;
      q = (mg + (longint'(NPTS) << (FRAC - 1))) / (longint'(NPTS) << FRAC);
      if (num < 0) q = -q;
      if (q > 131071) q = 131071;
      if (q < -131072) q = -131072;
      return q;
    endfunction

    // Magnitude and phase by CORDIC vectoring
    function void polar(input longint re, input longint im,
                        output logic [17:0] mag, output logic [15:0] ph);
      longint x, y, nx, m;
      logic [31:0] z;
      logic [31:0] zr;
      if (re == 0 && im == 0) begin
        mag = 0;
        ph = 0;
        return;
      end
      x = re <<< odft_pkg::VEC_EXTRA;
      y = im <<< odft_pkg::VEC_EXTRA;
      z = 0;
      if (x < 0) begin
        x = -x;
        y = -y;
        z = 32'h8000_0000;
      end
      for (int i = 0; i < odft_pkg::CORDIC_STEPS; i++) begin
        if (y > 0) begin
          nx = x + (y >>> i);
          y = y - (x >>> i);
          z = z + odft_pkg::ATAN_TURNS[i];
        end else begin
          nx = x - (y >>> i);
          y = y + (x >>> i);
          z = z - odft_pkg::ATAN_TURNS[i];
        end
        x = nx;
      end
      m = (x * longint'(odft_pkg::GAIN_INV) + (longint'(1) <<< (29 + odft_pkg::VEC_EXTRA)))
          >>> (30 + odft_pkg::VEC_EXTRA);
      if (m > 262143) m = 262143;
      if (m < 0) m = 0;
      mag = m[17:0];
      zr = z + 32'h8000;
      ph = zr[31:16];
    endfunction

    // Accumulate one accepted sample; on the frame's end queue every bin
    function void note_sample(input logic signed [15:0] smp);
      longint v, pr, pim, re, im;
      int m;
      bin_t b;
      v = longint'(smp);
      for (int k = 0; k < NBINS; k++) begin
        m = (k * pos) % NPTS;
        pr = v * cos_tab[m];
        pim = v * sin_tab[m];
        if (neg) pim = -pim;
        re_acc[k] = clip40(re_acc[k] + pr);
        im_acc[k] = clip40(im_acc[k] + pim);
      end
      pos++;
      if (pos < NPTS) return;
      for (int k = 0; k < NBINS; k++) begin
        re = scale_bin(re_acc[k]);
        im = scale_bin(im_acc[k]);
        b.idx = 7'(k);
        b.re = re[17:0];
        b.im = im[17:0];
        polar(re, im, b.mag, b.ph);
        b.last = (k == NBINS - 1);
        bins_q.push_back(b);
      end
      clear_frame();
    endfunction

    function void report(input string what, input bin_t e, input bin_t a);
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: %s mismatch: expected bin %0d re %0d im %0d mag %0d ph %0d last %0d,",
                 $realtime, what, e.idx, e.re, e.im, e.mag, e.ph, e.last,
                 " got bin %0d re %0d im %0d mag %0d ph %0d last %0d",
                 a.idx, a.re, a.im, a.mag, a.ph, a.last);
    endfunction

    // Compare one accepted result with the oldest expected bin
    function void check_bin(input bin_t a);
      bin_t e;
      bins_seen++;
      if (bins_q.size() == 0) begin
        e = '{default: 0};
        report("unexpected", e, a);
        return;
      end
      e = bins_q.pop_front();
      if (a.last) frames_seen++;
      if (a.idx !== e.idx || a.re !== e.re || a.im !== e.im || a.mag !== e.mag ||
          a.ph !== e.ph || a.last !== e.last)
        report("field", e, a);
    endfunction
  endclass

  logic               clk = 0;
  logic               rst_n = 0;
  logic               in_valid = 0;
  logic               in_stall;
  logic signed [15:0] in_sample = 0;
  logic               out_valid;
  logic               out_stall = 0;
  logic [6:0]         out_bin_index;
  logic signed [17:0] out_real_part;
  logic signed [17:0] out_imag_part;
  logic [17:0]        out_magnitude;
  logic signed [15:0] out_phase_angle;
  logic               out_last_bin;
  logic               psel = 0;
  logic               penable = 0;
  logic               pwrite = 0;
  logic [2:0]         paddr = 0;
  logic [31:0]        pwdata = 0;
  logic [31:0]        prdata;
  logic               pready;

  spectrum_sb sb = new();
  int burst_left = 0;
  int stall_mode = 0;
  int stall_left = 0;

  one_sided_dft_spectrum i_dut (
    .clk, .rst_n, .in_valid, .in_stall, .in_sample,
    .out_valid, .out_stall, .out_bin_index, .out_real_part, .out_imag_part,
    .out_magnitude, .out_phase_angle, .out_last_bin,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always #5 clk = ~clk;

  // Check results and advance the receiver's stall pattern
  always @(posedge clk) begin
    bin_t a;
    if (rst_n && out_valid && !out_stall) begin
      a.idx = out_bin_index;
      a.re = out_real_part;
      a.im = out_imag_part;
      a.mag = out_magnitude;
      a.ph = out_phase_angle;
      a.last = out_last_bin;
      sb.check_bin(a);
    end
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(20, 400);
    end
    stall_left--;
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 1) == 1);
      2: out_stall <= ($urandom_range(0, 7) == 0);
      default: out_stall <= ($urandom_range(0, 15) != 0);
    endcase
  end

  // Send one sample; hold it until the transaction completes, then maybe gap
  task automatic send_sample(input logic signed [15:0] v);
    in_valid <= 1'b1;
    in_sample <= v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_sample(v);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      if ($urandom_range(0, 2) != 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 60)) @(posedge clk);
      end
    end else begin
      burst_left--;
    end
  endtask

  // Register write: setup cycle, then access cycle
  task automatic reg_write(input logic [2:0] addr, input logic [31:0] data);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (addr == ADDR_NEGATE) sb.neg = data[0];
  endtask

  // Hold until every expected bin is back, then let the back end drain
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.bins_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic send_frame(input int kind);
    real bin_f;
    logic signed [15:0] v;
    bin_f = $urandom_range(0, NBINS - 1);
    for (int n = 0; n < NPTS; n++) begin
      case (kind)
        0: v = 16'($urandom);
        1: v = (n % 2) ? 16'sh7FFF : -16'sh8000;
        2: v = 16'($rtoi(32000.0 * $cos(2.0 * 3.14159265358979 * bin_f * n / NPTS)));
        default: v = 16'($signed($urandom_range(0, 511)) - 256);
      endcase
      send_sample(v);
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Full-scale negative DC with minus sine: negative real axis and zero bins
    reg_write(ADDR_NEGATE, 32'hFFFF_FFFF);
    for (int n = 0; n < NPTS; n++) send_sample(-16'sh8000);
    drain();

    // Plus sine; a write to an unused address is dropped
    reg_write(ADDR_NEGATE, 32'h0000_0000);
    reg_write(ADDR_UNUSED, 32'hFFFF_FFFF);
    send_frame($urandom_range(0, 3));
    drain();

    // Leave a partial frame behind; it yields nothing
    for (int n = 0; n < NPTS / 2; n++) send_sample(16'($urandom));
    drain();

    $display("Covered %0d frames, %0d bins checked: negative DC with minus sine,",
             sb.frames_seen, sb.bins_seen);
    $display("a generated frame with plus sine, an ignored write and a partial frame.");
    if (sb.mismatches == 0 && sb.bins_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("%0d mismatches", sb.mismatches);
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("Timeout");
    $display("Some tests failed");
    $finish;
  end

endmodule
